FILE: hw/rtl/prpt_pkg.sv
// ----------------------------------------------------------------------------
// prpt_pkg
// Shared types, codes and constants of the peer request pipeline tracker.
// ----------------------------------------------------------------------------
package prpt_pkg;

    localparam int OUTSTANDING_DEPTH_DEF = 16;
    localparam int WAITING_DEPTH_DEF     = 32;
    localparam int PIECE_LEN_DEF         = 16384;

    localparam int CMD_W         = 3;
    localparam int KIND_W        = 3;
    localparam int CHUNK_W       = 32;
    localparam int OFFSET_W      = 32;
    localparam int LENGTH_W      = 18;
    localparam int RATE_W        = 32;
    localparam int TIME_W        = 32;
    localparam int OCOUNT_W      = 5;
    localparam int WCOUNT_W      = 6;
    localparam int QLIMIT_W      = 16;
    localparam int WLIMIT_W      = 6;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 32;
    // Ten times a 32-bit rate, plus headroom for one piece step.
    localparam int SCALED_RATE_W = 36;

    localparam logic [TIME_W-1:0]   TIMEOUT_RESET    = 32'd60000;
    localparam logic [WLIMIT_W-1:0] WAIT_LIMIT_RESET = 6'd25;
    localparam logic [WLIMIT_W-1:0] WAIT_LIMIT_MIN   = 6'd10;
    localparam logic [WLIMIT_W-1:0] WAIT_LIMIT_MAX   = 6'd63;

    typedef enum logic [CMD_W-1:0] {
        CMD_DOWNLOAD   = 3'd0,
        CMD_CANCEL     = 3'd1,
        CMD_REJECTED   = 3'd2,
        CMD_PIECE      = 3'd3,
        CMD_CANCEL_ALL = 3'd4,
        CMD_CHOKED     = 3'd5,
        CMD_TICK       = 3'd6
    } cmd_e;

    typedef enum logic [KIND_W-1:0] {
        KIND_SEND_REQUEST = 3'd0,
        KIND_SEND_CANCEL  = 3'd1,
        KIND_REJECTED     = 3'd2,
        KIND_TIMED_OUT    = 3'd3,
        KIND_STATUS       = 3'd4
    } kind_e;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PEER_QUEUE_LIMIT = 2'd0,
        REG_FAST_EXT_ENABLED = 2'd1,
        REG_TIMEOUT_MS       = 2'd2
    } cfg_reg_e;

    typedef enum logic [2:0] {
        SW_MOVE,
        SW_MATCH_ALL,
        SW_FIRST_MATCH,
        SW_FLUSH,
        SW_EXPIRE
    } sweep_mode_e;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_PUSH,
        S_WIN,
        S_SW_INIT,
        S_SW_RD,
        S_SW_EV,
        S_CLEAR,
        S_EMIT,
        S_STATUS
    } state_e;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [CHUNK_W-1:0]  req_chunk;
        logic [OFFSET_W-1:0] block_offset;
        logic [LENGTH_W-1:0] block_length;
        logic [RATE_W-1:0]   rate_bps;
        logic [TIME_W-1:0]   now_ms;
    } cmd_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [CHUNK_W-1:0]  out_chunk;
        logic [OFFSET_W-1:0] out_offset;
        logic [LENGTH_W-1:0] out_length;
        logic                last;
        logic                can_add;
        logic [OCOUNT_W-1:0] outstanding_count;
        logic [WCOUNT_W-1:0] waiting_count;
        logic                overflow;
    } res_item_t;

    typedef struct packed {
        logic [CHUNK_W-1:0]  chunk;
        logic [OFFSET_W-1:0] offset;
        logic [LENGTH_W-1:0] length;
    } request_t;

    typedef struct packed {
        request_t          req;
        logic [TIME_W-1:0] stamp;
    } out_entry_t;

    typedef struct packed {
        logic        load_item;
        logic        push;
        logic        win_step;
        logic        sweep_init;
        logic        sweep_read;
        logic        sweep_eval;
        logic        sweep_sel_out;
        sweep_mode_e sweep_mode;
        kind_e       emit_kind;
        logic        emit_item;
        logic        emit_status;
        logic        clear_wait;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             fast_ext;
        logic             win_done;
        logic             sweep_end;
        logic             removed_any;
        logic             ev_emit;
        logic             out_free;
    } dp_status_t;

endpackage

FILE: hw/rtl/prpt_ctrl.sv
// ----------------------------------------------------------------------------
// prpt_ctrl
// Command sequencer: walks each command through its FIFO sweeps and results.
// ----------------------------------------------------------------------------
module prpt_ctrl
    import prpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  ctrl
);

    state_e state_reg;
    state_e state_next;
    logic   phase_reg;
    logic   phase_next;
    cmd_e   cmd;

    assign cmd = cmd_e'(status.command);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // Next state. Commands with two sweeps go through the sweep states twice.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                phase_next = 1'b0;
                if (cmd_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (cmd)
                    CMD_DOWNLOAD:   state_next = S_PUSH;
                    CMD_CANCEL,
                    CMD_REJECTED,
                    CMD_PIECE,
                    CMD_CANCEL_ALL,
                    CMD_TICK:       state_next = S_SW_INIT;
                    CMD_CHOKED:     state_next = status.fast_ext ? S_STATUS : S_SW_INIT;
                    default:        state_next = S_STATUS;
                endcase
            end
            S_PUSH:
            begin
                state_next = S_WIN;
            end
            S_WIN:
            begin
                if (status.win_done)
                begin
                    state_next = S_SW_INIT;
                end
            end
            S_SW_INIT:
            begin
                state_next = S_SW_RD;
            end
            S_SW_RD:
            begin
                if (!status.sweep_end)
                begin
                    state_next = S_SW_EV;
                end
                else
                begin
                    case (cmd)
                        CMD_CANCEL:
                        begin
                            if (phase_reg)
                            begin
                                state_next = S_EMIT;
                            end
                            else if (status.removed_any)
                            begin
                                state_next = S_STATUS;
                            end
                            else
                            begin
                                state_next = S_SW_INIT;
                                phase_next = 1'b1;
                            end
                        end
                        CMD_REJECTED:
                        begin
                            state_next = status.removed_any ? S_EMIT : S_STATUS;
                        end
                        CMD_PIECE:
                        begin
                            if (!phase_reg && !status.removed_any)
                            begin
                                state_next = S_SW_INIT;
                                phase_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_STATUS;
                            end
                        end
                        CMD_CANCEL_ALL:
                        begin
                            state_next = S_CLEAR;
                        end
                        CMD_CHOKED:
                        begin
                            if (!phase_reg)
                            begin
                                state_next = S_SW_INIT;
                                phase_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_STATUS;
                            end
                        end
                        default:
                        begin
                            state_next = S_STATUS;
                        end
                    endcase
                end
            end
            S_SW_EV:
            begin
                if (!status.ev_emit || status.out_free)
                begin
                    state_next = S_SW_RD;
                end
            end
            S_CLEAR:
            begin
                state_next = S_STATUS;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = S_STATUS;
                end
            end
            S_STATUS:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd_ready          = (state_reg == S_IDLE);
        ctrl               = '0;
        ctrl.sweep_mode    = SW_MATCH_ALL;
        ctrl.emit_kind     = KIND_STATUS;
        ctrl.load_item     = (state_reg == S_IDLE) && cmd_valid;
        ctrl.push          = (state_reg == S_PUSH);
        ctrl.win_step      = (state_reg == S_WIN);
        ctrl.sweep_init    = (state_reg == S_SW_INIT);
        ctrl.sweep_read    = (state_reg == S_SW_RD);
        ctrl.sweep_eval    = (state_reg == S_SW_EV) && (!status.ev_emit || status.out_free);
        ctrl.clear_wait    = (state_reg == S_CLEAR);
        ctrl.emit_item     = (state_reg == S_EMIT) && status.out_free;
        ctrl.emit_status   = (state_reg == S_STATUS) && status.out_free;

        case (cmd)
            CMD_DOWNLOAD:
            begin
                ctrl.sweep_sel_out = 1'b0;
                ctrl.sweep_mode    = SW_MOVE;
                ctrl.emit_kind     = KIND_SEND_REQUEST;
            end
            CMD_CANCEL:
            begin
                ctrl.sweep_sel_out = phase_reg;
                ctrl.sweep_mode    = SW_MATCH_ALL;
                ctrl.emit_kind     = KIND_SEND_CANCEL;
            end
            CMD_REJECTED:
            begin
                ctrl.sweep_sel_out = 1'b1;
                ctrl.sweep_mode    = SW_MATCH_ALL;
                ctrl.emit_kind     = KIND_REJECTED;
            end
            CMD_PIECE:
            begin
                ctrl.sweep_sel_out = !phase_reg;
                ctrl.sweep_mode    = phase_reg ? SW_MATCH_ALL : SW_FIRST_MATCH;
            end
            CMD_CANCEL_ALL:
            begin
                ctrl.sweep_sel_out = 1'b1;
                ctrl.sweep_mode    = SW_FLUSH;
                ctrl.emit_kind     = KIND_SEND_CANCEL;
            end
            CMD_CHOKED:
            begin
                ctrl.sweep_sel_out = !phase_reg;
                ctrl.sweep_mode    = SW_FLUSH;
                ctrl.emit_kind     = KIND_REJECTED;
            end
            CMD_TICK:
            begin
                ctrl.sweep_sel_out = 1'b1;
                ctrl.sweep_mode    = SW_EXPIRE;
                ctrl.emit_kind     = KIND_TIMED_OUT;
            end
            default:
            begin
                ctrl.sweep_sel_out = 1'b0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/prpt_datapath.sv
// ----------------------------------------------------------------------------
// prpt_datapath
// Request FIFOs, counters, window search, configuration and result register.
// ----------------------------------------------------------------------------
module prpt_datapath
    import prpt_pkg::*;
#(
    parameter int OUTSTANDING_DEPTH = OUTSTANDING_DEPTH_DEF,
    parameter int WAITING_DEPTH     = WAITING_DEPTH_DEF,
    parameter int PIECE_LEN         = PIECE_LEN_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  cmd_item_t              cmd_item,
    output logic                   res_valid,
    input  logic                   res_ready,
    output res_item_t              res_item,
    input  ctrl_cmd_t              ctrl,
    output dp_status_t             status
);

    localparam int WAW = $clog2(WAITING_DEPTH);
    localparam int WCW = $clog2(WAITING_DEPTH + 1);
    localparam int OAW = (OUTSTANDING_DEPTH > 1) ? $clog2(OUTSTANDING_DEPTH) : 1;
    localparam int OCW = $clog2(OUTSTANDING_DEPTH + 1);
    localparam int PW  = (WCW > OCW) ? WCW : OCW;
    localparam int LW  = QLIMIT_W + 1;

    localparam logic [SCALED_RATE_W-1:0] PIECE_STEP = SCALED_RATE_W'(PIECE_LEN);
    localparam logic [OCW-1:0]           OD_COUNT   = OCW'(OUTSTANDING_DEPTH);
    localparam logic [WCW-1:0]           WD_COUNT   = WCW'(WAITING_DEPTH);

    request_t   w_mem [WAITING_DEPTH];
    out_entry_t o_mem [OUTSTANDING_DEPTH];

    cmd_item_t              item_reg;
    logic [QLIMIT_W-1:0]    pql_reg;
    logic                   fast_reg;
    logic [TIME_W-1:0]      timeout_reg;
    logic [WCW-1:0]         wc_reg;
    logic [OCW-1:0]         oc_reg;
    logic [WLIMIT_W-1:0]    wlim_reg;
    logic [OCW-1:0]         win_reg;
    logic [OCW-1:0]         q_reg;
    logic [SCALED_RATE_W-1:0] acc_reg;
    logic [PW-1:0]          rp_reg;
    logic [PW-1:0]          wp_reg;
    logic                   removed_reg;
    logic                   kept_reg;
    logic                   ovf_reg;
    request_t               w_rd_reg;
    out_entry_t             o_rd_reg;
    logic                   res_valid_reg;
    res_item_t              res_item_reg;
    res_item_t              res_item_next;

    logic [SCALED_RATE_W-1:0] scaled_rate;
    logic                   win_done;
    logic [OCW:0]           q_plus;
    logic [OCW:0]           win_depth;
    logic [LW-1:0]          win_full;
    logic [LW-1:0]          win_capped;
    logic [LW-1:0]          lim_twice;
    logic [OCW-1:0]         win_new;
    logic [WLIMIT_W-1:0]    wlim_new;
    logic [PW-1:0]          sweep_cnt;
    logic                   sweep_end;
    request_t               item_req;
    request_t               ev_req;
    logic                   ev_match;
    logic                   ev_expired;
    logic                   ev_drop;
    logic                   ev_emit;
    logic                   out_free;
    logic                   w_we;
    logic [WAW-1:0]         w_waddr;
    request_t               w_wdata;
    logic                   o_we;
    logic [OAW-1:0]         o_waddr;
    out_entry_t             o_wdata;

    assign item_req    = '{chunk: item_reg.req_chunk, offset: item_reg.block_offset,
                           length: item_reg.block_length};
    assign scaled_rate = (SCALED_RATE_W'(item_reg.rate_bps) << 3)
                       + (SCALED_RATE_W'(item_reg.rate_bps) << 1);

    // Window search: counts whole pieces until they cover ten times the rate.
    assign win_done   = !((acc_reg < scaled_rate) && (q_reg < OD_COUNT));
    assign q_plus     = {1'b0, q_reg} + 1'b1;
    assign win_depth  = (q_plus > {1'b0, OD_COUNT}) ? {1'b0, OD_COUNT} : q_plus;
    assign win_full   = LW'(win_depth);
    assign win_capped = ((pql_reg != '0) && ({1'b0, pql_reg} < win_full))
                      ? {1'b0, pql_reg} : win_full;
    assign win_new    = win_capped[OCW-1:0];
    assign lim_twice  = win_capped << 1;

    always_comb
    begin
        if (lim_twice < LW'(WAIT_LIMIT_MIN))
        begin
            wlim_new = WAIT_LIMIT_MIN;
        end
        else if (lim_twice > LW'(WAIT_LIMIT_MAX))
        begin
            wlim_new = WAIT_LIMIT_MAX;
        end
        else
        begin
            wlim_new = lim_twice[WLIMIT_W-1:0];
        end
    end

    // Sweep evaluation of the entry just read.
    assign sweep_cnt  = ctrl.sweep_sel_out ? PW'(oc_reg) : PW'(wc_reg);
    assign sweep_end  = (rp_reg == sweep_cnt);
    assign ev_req     = ctrl.sweep_sel_out ? o_rd_reg.req : w_rd_reg;
    assign ev_match   = (ev_req == item_req);
    assign ev_expired = (item_reg.now_ms - o_rd_reg.stamp) > timeout_reg;
    assign out_free   = !res_valid_reg || res_ready;

    always_comb
    begin
        unique case (ctrl.sweep_mode)
            SW_MOVE:
            begin
                ev_drop = (oc_reg < win_reg);
                ev_emit = ev_drop;
            end
            SW_MATCH_ALL:
            begin
                ev_drop = ev_match;
                ev_emit = 1'b0;
            end
            SW_FIRST_MATCH:
            begin
                ev_drop = ev_match && !removed_reg;
                ev_emit = 1'b0;
            end
            SW_FLUSH:
            begin
                ev_drop = 1'b1;
                ev_emit = 1'b1;
            end
            SW_EXPIRE:
            begin
                ev_drop = ev_expired && !kept_reg;
                ev_emit = ev_drop;
            end
            default:
            begin
                ev_drop = 1'b0;
                ev_emit = 1'b0;
            end
        endcase
    end

    // Write ports.
    always_comb
    begin
        w_we    = 1'b0;
        w_waddr = wp_reg[WAW-1:0];
        w_wdata = ev_req;
        if (ctrl.push && (wc_reg < WD_COUNT))
        begin
            w_we    = 1'b1;
            w_waddr = wc_reg[WAW-1:0];
            w_wdata = item_req;
        end
        else if (ctrl.sweep_eval && !ctrl.sweep_sel_out && !ev_drop)
        begin
            w_we = 1'b1;
        end
    end

    always_comb
    begin
        o_we    = 1'b0;
        o_waddr = wp_reg[OAW-1:0];
        o_wdata = o_rd_reg;
        if (ctrl.sweep_eval && (ctrl.sweep_mode == SW_MOVE) && ev_drop)
        begin
            o_we    = 1'b1;
            o_waddr = oc_reg[OAW-1:0];
            o_wdata = '{req: w_rd_reg, stamp: item_reg.now_ms};
        end
        else if (ctrl.sweep_eval && ctrl.sweep_sel_out && !ev_drop)
        begin
            o_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            w_mem[w_waddr] <= w_wdata;
        end
        if (ctrl.sweep_read && !sweep_end && !ctrl.sweep_sel_out)
        begin
            w_rd_reg <= w_mem[rp_reg[WAW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_we)
        begin
            o_mem[o_waddr] <= o_wdata;
        end
        if (ctrl.sweep_read && !sweep_end && ctrl.sweep_sel_out)
        begin
            o_rd_reg <= o_mem[rp_reg[OAW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            item_reg <= cmd_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pql_reg     <= '0;
            fast_reg    <= 1'b0;
            timeout_reg <= TIMEOUT_RESET;
            wc_reg      <= '0;
            oc_reg      <= '0;
            wlim_reg    <= WAIT_LIMIT_RESET;
            win_reg     <= '0;
            q_reg       <= '0;
            acc_reg     <= '0;
            rp_reg      <= '0;
            wp_reg      <= '0;
            removed_reg <= 1'b0;
            kept_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PEER_QUEUE_LIMIT: pql_reg     <= cfg_data[QLIMIT_W-1:0];
                    REG_FAST_EXT_ENABLED: fast_reg    <= cfg_data[0];
                    REG_TIMEOUT_MS:       timeout_reg <= cfg_data[TIME_W-1:0];
                    default:              ;
                endcase
            end
            if (ctrl.load_item)
            begin
                ovf_reg <= 1'b0;
            end
            if (ctrl.push)
            begin
                acc_reg <= '0;
                q_reg   <= '0;
                if (wc_reg < WD_COUNT)
                begin
                    wc_reg <= wc_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (ctrl.win_step)
            begin
                if (!win_done)
                begin
                    acc_reg <= acc_reg + PIECE_STEP;
                    q_reg   <= q_reg + 1'b1;
                end
                else
                begin
                    win_reg  <= win_new;
                    wlim_reg <= wlim_new;
                end
            end
            if (ctrl.sweep_init)
            begin
                rp_reg      <= '0;
                wp_reg      <= '0;
                removed_reg <= 1'b0;
                kept_reg    <= 1'b0;
            end
            if (ctrl.sweep_read && sweep_end)
            begin
                if (ctrl.sweep_sel_out)
                begin
                    oc_reg <= OCW'(wp_reg);
                end
                else
                begin
                    wc_reg <= WCW'(wp_reg);
                end
            end
            if (ctrl.sweep_eval)
            begin
                rp_reg <= rp_reg + 1'b1;
                if (ev_drop)
                begin
                    removed_reg <= 1'b1;
                    if (ctrl.sweep_mode == SW_MOVE)
                    begin
                        oc_reg <= oc_reg + 1'b1;
                    end
                end
                else
                begin
                    wp_reg   <= wp_reg + 1'b1;
                    kept_reg <= 1'b1;
                end
            end
            if (ctrl.clear_wait)
            begin
                wc_reg <= '0;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctrl.emit_item || ctrl.emit_status || (ctrl.sweep_eval && ev_emit))
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        res_item_next = res_item_reg;
        if (ctrl.emit_status)
        begin
            res_item_next                   = '0;
            res_item_next.kind              = KIND_STATUS;
            res_item_next.last              = 1'b1;
            res_item_next.can_add           = (7'(wc_reg) < 7'(wlim_reg));
            res_item_next.outstanding_count = OCOUNT_W'(oc_reg);
            res_item_next.waiting_count     = WCOUNT_W'(wc_reg);
            res_item_next.overflow          = ovf_reg;
        end
        else if (ctrl.emit_item)
        begin
            res_item_next            = '0;
            res_item_next.kind       = ctrl.emit_kind;
            res_item_next.out_chunk  = item_req.chunk;
            res_item_next.out_offset = item_req.offset;
            res_item_next.out_length = item_req.length;
        end
        else if (ctrl.sweep_eval && ev_emit)
        begin
            res_item_next            = '0;
            res_item_next.kind       = ctrl.emit_kind;
            res_item_next.out_chunk  = ev_req.chunk;
            res_item_next.out_offset = ev_req.offset;
            res_item_next.out_length = ev_req.length;
        end
    end

    always_ff @(posedge clk)
    begin
        res_item_reg <= res_item_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    assign status.command     = item_reg.command;
    assign status.fast_ext    = fast_reg;
    assign status.win_done    = win_done;
    assign status.sweep_end   = sweep_end;
    assign status.removed_any = removed_reg;
    assign status.ev_emit     = ev_emit;
    assign status.out_free    = out_free;

endmodule

FILE: hw/rtl/peer_request_pipeline_tracker.sv
// ----------------------------------------------------------------------------
// peer_request_pipeline_tracker
// Waiting and outstanding block request FIFOs for one peer.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the cmd channel (valid/ready); one transfer carries one
// command with the request it names, the peer rate and the current time.
// Results leave on the res channel (valid/ready); every command produces zero
// or more request results followed by exactly one status result with last
// set. Configuration registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while no command is in flight, as the block
// does not enforce it. The block handles one command at a time. Each FIFO
// sweep has a start step, then for each stored entry a registered memory
// read and an evaluate and write-back step, then a closing read. A download
// first pushes its request, then counts pieces in the window search up to
// OUTSTANDING_DEPTH and closes it with one more step. Every command also
// passes a dispatch step and a status step, and a cancel or reject that
// names its request in a result adds an emit step.
// When the receiver stalls, the result register holds its transfer and the
// sweep waits on it; cmd_ready rises again once the status result has been
// loaded, so the next command can be accepted while the status still waits.
// Reset empties both FIFOs, sets the wait limit to 25 and loads the
// configuration defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module peer_request_pipeline_tracker
    import prpt_pkg::*;
#(
    parameter int OUTSTANDING_DEPTH = OUTSTANDING_DEPTH_DEF,
    parameter int WAITING_DEPTH     = WAITING_DEPTH_DEF,
    parameter int PIECE_LEN         = PIECE_LEN_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   cmd_valid,
    output logic                   cmd_ready,
    input  cmd_item_t              cmd_item,
    output logic                   res_valid,
    input  logic                   res_ready,
    output res_item_t              res_item
);

    // The controller reads status; all FIFO storage sits in the datapath.
    ctrl_cmd_t  ctrl;
    dp_status_t status;

    prpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .status    (status),
        .ctrl      (ctrl)
    );

    prpt_datapath #(
        .OUTSTANDING_DEPTH (OUTSTANDING_DEPTH),
        .WAITING_DEPTH     (WAITING_DEPTH),
        .PIECE_LEN         (PIECE_LEN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .ctrl      (ctrl),
        .status    (status)
    );

endmodule

FILE: hw/rtl/prpt_checker.sv
// ----------------------------------------------------------------------------
// prpt_checker
// Port-level checks of the peer request pipeline tracker.
// ----------------------------------------------------------------------------
module prpt_checker
    import prpt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_valid,
    input logic      cmd_ready,
    input logic      res_valid,
    input logic      res_ready,
    input res_item_t res_item
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_item))
        else $error("result changed while stalled");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("second command accepted while one is in flight");

    a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_item.kind == KIND_STATUS) |->
            res_item.last && (res_item.out_chunk == '0) && (res_item.out_offset == '0)
            && (res_item.out_length == '0))
        else $error("malformed status result");

    a_entry_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_item.kind != KIND_STATUS) |->
            !res_item.last && !res_item.can_add && !res_item.overflow
            && (res_item.outstanding_count == '0) && (res_item.waiting_count == '0))
        else $error("malformed request result");

endmodule

bind peer_request_pipeline_tracker prpt_checker u_prpt_checker (.*);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Peer request pipeline tracker testbench
// Drives commands through the valid/ready command channel and predicts every
// request, cancel, reject, timeout and status transfer with a behavioral copy
// of both request FIFOs. A directed table comes first, then random traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import prpt_pkg::*;

    localparam int OUT_DEPTH  = 16;
    localparam int WAIT_DEPTH = 32;
    localparam int PIECE      = 16384;
    localparam int IDLE_LIMIT = 20000;
    // Enough cycles for the slowest command to finish its sweeps.
    localparam int DRAIN_CYCLES = 400;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    cfg_reg_e    cfg_index;
    logic [31:0] cfg_data;
    logic        cmd_valid;
    logic        cmd_ready;
    cmd_item_t   cmd_item;
    logic        res_valid;
    logic        res_ready;
    res_item_t   res_item;

    peer_request_pipeline_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Predictor state: a mirror of both FIFOs and the configuration.
    request_t    pend_q[$];
    out_entry_t  sent_q[$];
    logic [5:0]  wait_lim;
    logic [15:0] queue_limit;
    logic        fast_ext;
    logic [31:0] timeout_val;

    res_item_t   expected_q[$];
    bit          failed;
    int          idle_cycles;

    // Pool of requests so that cancels, rejects and pieces hit real entries.
    request_t    req_pool[8];

    function automatic res_item_t make_req_res(kind_e k, request_t r);
        res_item_t x;
        x = '0;
        x.kind       = k;
        x.out_chunk  = r.chunk;
        x.out_offset = r.offset;
        x.out_length = r.length;
        return x;
    endfunction

    function automatic bit same_req(request_t a, request_t b);
        return a.chunk == b.chunk && a.offset == b.offset && a.length == b.length;
    endfunction

    // Works out the results of one command and updates the mirror state.
    task automatic predict_command(cmd_item_t c);
        request_t   r;
        out_entry_t e;
        logic [63:0] win;
        logic [63:0] lim;
        res_item_t  st;
        bit         ovf;
        int         hits;
        int         i;
        r.chunk  = c.req_chunk;
        r.offset = c.block_offset;
        r.length = c.block_length;
        ovf = 1'b0;
        case (c.command)
            CMD_DOWNLOAD:
            begin
                if (pend_q.size() < WAIT_DEPTH)
                    pend_q.push_back(r);
                else
                    ovf = 1'b1;
                win = 1 + (64'(c.rate_bps) * 10 + PIECE - 1) / PIECE;
                if (queue_limit != 0 && win > queue_limit)
                    win = queue_limit;
                if (win > OUT_DEPTH)
                    win = OUT_DEPTH;
                while (pend_q.size() > 0 && sent_q.size() < win)
                begin
                    e.req   = pend_q[0];
                    pend_q.delete(0);
                    e.stamp = c.now_ms;
                    sent_q.push_back(e);
                    expected_q.push_back(make_req_res(KIND_SEND_REQUEST, e.req));
                end
                lim = 2 * win;
                if (lim < 10)
                    lim = 10;
                if (lim > 63)
                    lim = 63;
                wait_lim = lim[5:0];
            end
            CMD_CANCEL:
            begin
                hits = 0;
                for (i = pend_q.size() - 1; i >= 0; i--)
                    if (same_req(pend_q[i], r))
                    begin
                        pend_q.delete(i);
                        hits++;
                    end
                if (hits == 0)
                begin
                    for (i = sent_q.size() - 1; i >= 0; i--)
                        if (same_req(sent_q[i].req, r))
                            sent_q.delete(i);
                    expected_q.push_back(make_req_res(KIND_SEND_CANCEL, r));
                end
            end
            CMD_REJECTED:
            begin
                hits = 0;
                for (i = sent_q.size() - 1; i >= 0; i--)
                    if (same_req(sent_q[i].req, r))
                    begin
                        sent_q.delete(i);
                        hits++;
                    end
                if (hits != 0)
                    expected_q.push_back(make_req_res(KIND_REJECTED, r));
            end
            CMD_PIECE:
            begin
                hits = -1;
                for (i = 0; i < sent_q.size(); i++)
                    if (hits < 0 && same_req(sent_q[i].req, r))
                        hits = i;
                if (hits >= 0)
                    sent_q.delete(hits);
                else
                    for (i = pend_q.size() - 1; i >= 0; i--)
                        if (same_req(pend_q[i], r))
                            pend_q.delete(i);
            end
            CMD_CANCEL_ALL:
            begin
                foreach (sent_q[k])
                    expected_q.push_back(make_req_res(KIND_SEND_CANCEL, sent_q[k].req));
                sent_q.delete();
                pend_q.delete();
            end
            CMD_CHOKED:
            begin
                if (!fast_ext)
                begin
                    foreach (sent_q[k])
                        expected_q.push_back(make_req_res(KIND_REJECTED, sent_q[k].req));
                    foreach (pend_q[k])
                        expected_q.push_back(make_req_res(KIND_REJECTED, pend_q[k]));
                    sent_q.delete();
                    pend_q.delete();
                end
            end
            CMD_TICK:
            begin
                while (sent_q.size() > 0 && (c.now_ms - sent_q[0].stamp) > timeout_val)
                begin
                    e = sent_q[0];
                    sent_q.delete(0);
                    expected_q.push_back(make_req_res(KIND_TIMED_OUT, e.req));
                end
            end
            default:
            begin
            end
        endcase
        st = '0;
        st.kind              = KIND_STATUS;
        st.last              = 1'b1;
        st.can_add           = pend_q.size() < wait_lim;
        st.outstanding_count = 5'(sent_q.size());
        st.waiting_count     = 6'(pend_q.size());
        st.overflow          = ovf;
        expected_q.push_back(st);
    endtask

    // Result checker: the receiver stalls on a slowly changing pattern of its
    // own, with long stretches where it never stalls at all.
    int stall_mode;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready  <= 1'b0;
            stall_mode <= 0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: res_ready <= 1'b1;
                1: res_ready <= $urandom_range(0, 3) != 0;
                default: res_ready <= $urandom_range(0, 3) == 0;
            endcase
            if (res_valid && res_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, got %p", $time, res_item);
                    failed = 1'b1;
                end
                else
                begin
                    res_item_t x;
                    x = expected_q[0];
                    expected_q.delete(0);
                    if (x !== res_item)
                    begin
                        $display("%0t: result mismatch, expected %p, got %p",
                                 $time, x, res_item);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles without any transfer on either channel.
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // Presents one command and waits for its transfer, then predicts it.
    task automatic send_command(cmd_item_t c);
        cmd_valid <= 1'b1;
        cmd_item  <= c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        predict_command(c);
    endtask

    task automatic pause_sender(int cycles);
        cmd_valid <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    // Waits for every expected result, then lets the block settle.
    task automatic wait_quiet();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_PEER_QUEUE_LIMIT: queue_limit = val[15:0];
            REG_FAST_EXT_ENABLED: fast_ext    = val[0];
            default:              timeout_val = val;
        endcase
        @(posedge clk);
    endtask

    function automatic cmd_item_t make_cmd(cmd_e op, request_t r, logic [31:0] rate,
                                           logic [31:0] now);
        cmd_item_t c;
        c.command      = op;
        c.req_chunk    = r.chunk;
        c.block_offset = r.offset;
        c.block_length = r.length;
        c.rate_bps     = rate;
        c.now_ms       = now;
        return c;
    endfunction

    // Picks a request, mostly from the pool so that later commands match it.
    function automatic request_t pick_request();
        request_t r;
        if ($urandom_range(0, 9) < 8)
            return req_pool[$urandom_range(0, 7)];
        r.chunk  = $urandom();
        r.offset = $urandom();
        r.length = 18'($urandom_range(0, 131072));
        return r;
    endfunction

    // Directed table. Rows that carry a typed status are read straight off
    // the behavior: after reset, after the first download, after cancel all.
    typedef struct {
        cmd_e        op;
        int          pool_slot;
        logic [31:0] rate;
        logic [31:0] now;
        bit          has_status;
        res_item_t   status;
    } row_t;

    function automatic res_item_t status_of(bit can, int oc, int wc, bit ovf);
        res_item_t s;
        s = '0;
        s.kind              = KIND_STATUS;
        s.last              = 1'b1;
        s.can_add           = can;
        s.outstanding_count = 5'(oc);
        s.waiting_count     = 6'(wc);
        s.overflow          = ovf;
        return s;
    endfunction

    row_t dir_table[$];
    cmd_item_t cur;
    logic [31:0] clock_ms;
    int n_items;
    int i;

    initial
    begin
        failed      = 1'b0;
        idle_cycles = 0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_PEER_QUEUE_LIMIT;
        cfg_data    = '0;
        cmd_valid   = 1'b0;
        cmd_item    = '0;
        wait_lim    = 6'd25;
        queue_limit = '0;
        fast_ext    = 1'b0;
        timeout_val = 32'd60000;
        clock_ms    = 32'd0;

        req_pool[0] = '{32'h0, 32'h0, 18'h0};
        req_pool[1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 18'd131072};
        req_pool[2] = '{32'h0000_0005, 32'h0000_4000, 18'd16384};
        for (i = 3; i < 8; i++)
            req_pool[i] = '{$urandom(), $urandom(), 18'($urandom_range(0, 131072))};

        // Slot 0 is all zero; slot 1 has all-ones chunk and offset.
        dir_table.push_back('{CMD_TICK, 0, 0, 0, 1, status_of(1, 0, 0, 0)});
        dir_table.push_back('{CMD_DOWNLOAD, 1, 0, 100, 1, status_of(1, 1, 0, 0)});
        dir_table.push_back('{CMD_DOWNLOAD, 2, 0, 100, 0, '0});
        dir_table.push_back('{CMD_DOWNLOAD, 0, 32'hFFFF_FFFF, 200, 0, '0});
        dir_table.push_back('{CMD_PIECE, 2, 0, 300, 0, '0});
        dir_table.push_back('{CMD_CANCEL, 1, 0, 300, 0, '0});
        dir_table.push_back('{CMD_CANCEL, 3, 0, 300, 0, '0});
        dir_table.push_back('{CMD_REJECTED, 0, 0, 300, 0, '0});
        dir_table.push_back('{CMD_REJECTED, 4, 0, 300, 0, '0});
        dir_table.push_back('{CMD_DOWNLOAD, 3, 16384, 400, 0, '0});
        dir_table.push_back('{CMD_DOWNLOAD, 4, 16384, 400, 0, '0});
        dir_table.push_back('{CMD_TICK, 0, 0, 32'd60400, 0, '0});
        dir_table.push_back('{CMD_TICK, 0, 0, 32'd60401, 0, '0});
        dir_table.push_back('{CMD_DOWNLOAD, 5, 0, 32'hFFFF_FFF0, 0, '0});
        dir_table.push_back('{CMD_DOWNLOAD, 6, 0, 32'hFFFF_FFF0, 0, '0});
        dir_table.push_back('{CMD_CHOKED, 0, 0, 0, 0, '0});
        dir_table.push_back('{CMD_CANCEL_ALL, 0, 0, 0, 1, status_of(1, 0, 0, 0)});

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[k])
        begin
            cur = make_cmd(dir_table[k].op, req_pool[dir_table[k].pool_slot],
                           dir_table[k].rate, dir_table[k].now);
            send_command(cur);
            if (dir_table[k].has_status && expected_q[$] !== dir_table[k].status)
            begin
                $display("%0t: table row %0d status, expected %p, got %p", $time, k,
                         dir_table[k].status, expected_q[$]);
                failed = 1'b1;
            end
        end

        // Overflow of the waiting FIFO with a queue limit of one: the first
        // download is sent, then 32 wait, and the next one is dropped.
        wait_quiet();
        write_reg(REG_PEER_QUEUE_LIMIT, 32'd1);
        for (i = 0; i < WAIT_DEPTH + 2; i++)
            send_command(make_cmd(CMD_DOWNLOAD, req_pool[i % 8], 0, 500));
        if (expected_q[$] !== status_of(0, 1, 32, 1))
        begin
            $display("%0t: overflow status, expected %p, got %p", $time,
                     status_of(0, 1, 32, 1), expected_q[$]);
            failed = 1'b1;
        end
        send_command(make_cmd(CMD_CHOKED, req_pool[0], 0, 0));

        // Fast extensions: a choke leaves everything in place.
        wait_quiet();
        write_reg(REG_FAST_EXT_ENABLED, 32'd1);
        write_reg(REG_TIMEOUT_MS, 32'hFFFF_FFFF);
        write_reg(REG_PEER_QUEUE_LIMIT, 32'd65535);
        send_command(make_cmd(CMD_DOWNLOAD, req_pool[3], 32'd500000, 0));
        send_command(make_cmd(CMD_CHOKED, req_pool[0], 0, 0));
        send_command(make_cmd(CMD_TICK, req_pool[0], 0, 32'hFFFF_FFFF));

        // Random phases with their own configuration. Half the commands are
        // downloads from the pool so the FIFOs fill and later matches hit.
        n_items = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_quiet();
            case (phase)
                0:
                begin
                    write_reg(REG_PEER_QUEUE_LIMIT, 32'd0);
                    write_reg(REG_FAST_EXT_ENABLED, 32'd0);
                    write_reg(REG_TIMEOUT_MS, 32'd1);
                end
                1:
                begin
                    write_reg(REG_PEER_QUEUE_LIMIT, 32'd3);
                    write_reg(REG_TIMEOUT_MS, 32'd50);
                end
                2:
                begin
                    write_reg(REG_FAST_EXT_ENABLED, 32'd1);
                    write_reg(REG_PEER_QUEUE_LIMIT, $urandom());
                    write_reg(REG_TIMEOUT_MS, $urandom());
                end
                default:
                begin
                    write_reg(REG_FAST_EXT_ENABLED, 32'd0);
                    write_reg(REG_PEER_QUEUE_LIMIT, 32'd0);
                    write_reg(REG_TIMEOUT_MS, 32'd60000);
                end
            endcase
            for (int burst = 0; n_items < 32 * (phase + 1); burst++)
            begin
                int len;
                len = $urandom_range(1, 12);
                for (int b = 0; b < len; b++)
                begin
                    int pick;
                    cmd_e op;
                    logic [31:0] rate;
                    pick = $urandom_range(0, 99);
                    if (pick < 50)      op = CMD_DOWNLOAD;
                    else if (pick < 60) op = CMD_CANCEL;
                    else if (pick < 68) op = CMD_REJECTED;
                    else if (pick < 80) op = CMD_PIECE;
                    else if (pick < 84) op = CMD_CANCEL_ALL;
                    else if (pick < 88) op = CMD_CHOKED;
                    else                op = CMD_TICK;
                    clock_ms = clock_ms + $urandom_range(0, 40);
                    if ($urandom_range(0, 19) == 0)
                        clock_ms = $urandom();
                    case ($urandom_range(0, 3))
                        0: rate = $urandom();
                        1: rate = 0;
                        default: rate = $urandom_range(0, 40000);
                    endcase
                    cur = make_cmd(op, pick_request(), rate, clock_ms);
                    cur.command = op;
                    send_command(cur);
                    n_items++;
                end
                if ($urandom_range(0, 2) == 0)
                    pause_sender($urandom_range(1, 60));
            end
            // Hold off once until every result has come back.
            if (phase == 1)
                wait_quiet();
        end

        cmd_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (!failed)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/prpt_pkg.sv
hw/rtl/prpt_ctrl.sv
hw/rtl/prpt_datapath.sv
hw/rtl/peer_request_pipeline_tracker.sv
hw/rtl/prpt_checker.sv
tb/tb.sv
